// ===== rtl/core/pcs_pkg.sv =====
package pcs_pkg;

  localparam int COORD_W = 32;
  localparam int VAL_W = 32;
  localparam int LOCAL_W = 16;
  localparam int KIND_W = 3;
  localparam int MAX_STRAND_POINTS = 65536;
  localparam logic [LOCAL_W-1:0] LOCAL_LIMIT = LOCAL_W'(MAX_STRAND_POINTS - 1);

  localparam logic [VAL_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] DEG90_Q16 = 32'd5898240;
  localparam logic [VAL_W-1:0] DEG180_Q16 = 32'd11796480;
  localparam logic [VAL_W-1:0] PI_OVER_90_Q32 = 32'd149922641;

  localparam int CORDIC_STEPS = 20;
  localparam int ATAN_W = 22;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEGMENT,
    KIND_POINT,
    KIND_TOTALS,
    KIND_SEGLEN,
    KIND_ANGLE_DIFF,
    KIND_RECIP,
    KIND_ANGLE,
    KIND_CURVATURE
  } kind_t;

  // atan(2^-i) in Q16.16 degrees.
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [4:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/pcs_point_if.sv =====
interface pcs_point_if;
  logic valid;
  logic ready;
  logic signed [pcs_pkg::COORD_W-1:0] coord_x;
  logic signed [pcs_pkg::COORD_W-1:0] coord_y;
  logic signed [pcs_pkg::COORD_W-1:0] coord_z;
  logic end_of_strand;

  modport source(output valid, coord_x, coord_y, coord_z, end_of_strand, input ready);
  modport sink(input valid, coord_x, coord_y, coord_z, end_of_strand, output ready);
endinterface

// ===== rtl/core/pcs_record_if.sv =====
interface pcs_record_if;
  logic valid;
  logic ready;
  logic [pcs_pkg::KIND_W-1:0] record_kind;
  logic [pcs_pkg::VAL_W-1:0] strand_number;
  logic [pcs_pkg::LOCAL_W-1:0] local_number;
  logic [pcs_pkg::VAL_W-1:0] global_number;
  logic [pcs_pkg::VAL_W-1:0] value_a;
  logic [pcs_pkg::VAL_W-1:0] value_b;
  logic [pcs_pkg::VAL_W-1:0] value_c;
  logic last_record;

  modport source(output valid, record_kind, strand_number, local_number, global_number,
                 value_a, value_b, value_c, last_record, input ready);
  modport sink(input valid, record_kind, strand_number, local_number, global_number,
               value_a, value_b, value_c, last_record, output ready);
endinterface

// ===== rtl/core/polyline_curvature_stats.sv =====
// An interior point works through three lengths (each three squares plus a 32-step root), then a
// 30-step division, a 32-step root, 20 CORDIC steps and 34- and 36-step divisions, all on one
// shared 65-bit subtractor and one 33x33 multiplier. Records then leave one per cycle (up to
// nine) while the record port is ready; the first two points of a strand take less.
// Throughput: one item at a time; the point port is ready only while the sequencer is idle.
// Reset (synchronous, rst high) clears the counters, sums, maxima and last/before coordinates; minima go to all ones.
module polyline_curvature_stats (
  input logic clk,
  input logic rst,
  pcs_point_if.sink points,
  pcs_record_if.source records
);

  typedef enum logic [4:0] {
    S_IDLE, S_LEN_MUL, S_LEN_ACC, S_LEN_SQ, S_ROOT, S_ROOT_END, S_W_START, S_W_MUL,
    S_W_ACC, S_W_CMP, S_W_CHK, S_DIV, S_DIV_END, S_Q_SQ, S_SN_INIT, S_COR_INIT, S_COR,
    S_COR_END, S_REC_INIT, S_CUR_MUL, S_CUR_INIT, S_EMIT_INIT, S_EMIT, S_FINISH
  } state_t;

  typedef enum logic [2:0] {E_NONE, E_SEG, E_PT, E_LSEG, E_TOT, E_EXT} emit_t;
  typedef enum logic [1:0] {D_COS, D_REC, D_CUR} div_tgt_t;
  typedef enum logic {T_LEN, T_SN} root_tgt_t;

  state_t state;
  emit_t emit_step;
  div_tgt_t div_tgt;
  root_tgt_t root_tgt;

  // Architectural state.
  logic [31:0] last_x, last_y, last_z, before_x, before_y, before_z;
  logic [15:0] point_in_strand;
  logic [31:0] strand_count, pt_total, segment_count;
  logic [31:0] previous_angle, length_sum, angle_sum;
  logic [31:0] mx [5];
  logic [31:0] mn [5];

  // Current item.
  logic [31:0] cx, cy, cz;
  logic eos;
  logic [15:0] k;

  // Datapath.
  logic [31:0] la, lb, lc;
  logic [1:0] len_sel, axis, widx;
  logic [66:0] acc;
  logic [65:0] prod;
  logic [64:0] rem;
  logic [63:0] sq_r, sq_b, den, sum2, ccr;
  logic [35:0] feed, quo;
  logic [5:0] cnt;
  logic cos_neg;
  logic [30:0] q;
  logic [30:0] sn;
  logic signed [33:0] cor_x, cor_y;
  logic signed [25:0] cor_z;
  logic [4:0] cor_i;
  logic [31:0] ang, rec, cur;
  logic [2:0] ext_slot;

  // Output register.
  logic out_valid, o_last;
  logic [2:0] o_kind;
  logic [15:0] o_local;
  logic [31:0] o_strand, o_global, o_a, o_b, o_c;

  function automatic logic [31:0] sat_add(input logic [31:0] x, input logic [31:0] y);
    logic [32:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[32] ? pcs_pkg::ALL_ONES : s[31:0];
  endfunction

  // Length operands: lb is current to last, la is last to before, lc is current to before.
  logic [31:0] pa, pb;
  logic [32:0] dif, absd;
  always_comb begin
    case (axis)
      2'd0: begin
        pa = (len_sel == 2'd1) ? last_x : cx;
        pb = (len_sel == 2'd0) ? last_x : before_x;
      end
      2'd1: begin
        pa = (len_sel == 2'd1) ? last_y : cy;
        pb = (len_sel == 2'd0) ? last_y : before_y;
      end
      default: begin
        pa = (len_sel == 2'd1) ? last_z : cz;
        pb = (len_sel == 2'd0) ? last_z : before_z;
      end
    endcase
    dif = {pa[31], pa} - {pb[31], pb};
    absd = dif[32] ? (~dif + 33'd1) : dif;
  end

  // Sides for the cosine, halved rounding up when any is 2^31 or more.
  logic sh;
  logic [32:0] ra, rb, rc;
  logic [31:0] wa, wb, wc;
  always_comb begin
    sh = la[31] | lb[31] | lc[31];
    ra = {1'b0, la} + {32'b0, sh};
    rb = {1'b0, lb} + {32'b0, sh};
    rc = {1'b0, lc} + {32'b0, sh};
    wa = sh ? ra[32:1] : ra[31:0];
    wb = sh ? rb[32:1] : rb[31:0];
    wc = sh ? rc[32:1] : rc[31:0];
  end

  // Shared multiplier.
  logic [32:0] mul_a, mul_b;
  always_comb begin
    case (state)
      S_LEN_MUL: begin
        mul_a = absd;
        mul_b = absd;
      end
      S_W_MUL: begin
        case (widx)
          2'd0: begin mul_a = {1'b0, wa}; mul_b = {1'b0, wa}; end
          2'd1: begin mul_a = {1'b0, wb}; mul_b = {1'b0, wb}; end
          2'd2: begin mul_a = {1'b0, wc}; mul_b = {1'b0, wc}; end
          default: begin mul_a = {1'b0, wa}; mul_b = {1'b0, wb}; end
        endcase
      end
      S_Q_SQ: begin
        mul_a = {2'b0, q};
        mul_b = {2'b0, q};
      end
      S_CUR_MUL: begin
        mul_a = {1'b0, ang};
        mul_b = {1'b0, pcs_pkg::PI_OVER_90_Q32};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared subtractor for square roots and long division.
  logic [64:0] sub_l, sub_r, sub_d;
  logic [65:0] sub_full;
  logic sub_ge;
  always_comb begin
    if (state == S_ROOT) begin
      sub_l = rem;
      sub_r = {1'b0, sq_r + sq_b};
    end else begin
      sub_l = {rem[63:0], feed[35]};
      sub_r = {1'b0, den};
    end
    sub_full = {1'b0, sub_l} - {1'b0, sub_r};
    sub_ge = !sub_full[65];
    sub_d = sub_full[64:0];
  end

  logic len_store;
  logic [31:0] len_value;
  always_comb begin
    len_store = ((state == S_LEN_SQ) && (acc[66:64] != 3'd0)) ||
                ((state == S_ROOT_END) && (root_tgt == T_LEN));
    len_value = (state == S_LEN_SQ) ? pcs_pkg::ALL_ONES : sq_r[31:0];
  end

  logic signed [33:0] cor_xs, cor_ys;
  logic signed [25:0] cor_at;
  logic signed [33:0] x0;
  always_comb begin
    cor_xs = cor_x >>> cor_i;
    cor_ys = cor_y >>> cor_i;
    cor_at = $signed({4'b0, pcs_pkg::atan_deg(cor_i)});
    x0 = cos_neg ? $signed({3'b0, q}) : -$signed({3'b0, q});
  end

  logic [31:0] diffv, seg_diff;
  logic out_free, emit_fire;
  always_comb begin
    diffv = (ang > previous_angle) ? (ang - previous_angle) : (previous_angle - ang);
    seg_diff = (k >= 16'd3) ? diffv : 32'd0;
    out_free = !out_valid || records.ready;
    emit_fire = (state == S_EMIT) && (emit_step != E_NONE) && out_free;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      last_x <= '0; last_y <= '0; last_z <= '0;
      before_x <= '0; before_y <= '0; before_z <= '0;
      point_in_strand <= '0;
      strand_count <= '0;
      pt_total <= '0;
      segment_count <= '0;
      previous_angle <= '0;
      length_sum <= '0;
      angle_sum <= '0;
      for (int i = 0; i < 5; i++) begin
        mx[i] <= '0;
        mn[i] <= pcs_pkg::ALL_ONES;
      end
    end else begin
      if (out_valid && records.ready && !emit_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (points.valid) begin
            cx <= points.coord_x;
            cy <= points.coord_y;
            cz <= points.coord_z;
            eos <= points.end_of_strand;
            k <= point_in_strand;
            len_sel <= 2'd0;
            axis <= 2'd0;
            state <= (point_in_strand != 16'd0) ? S_LEN_MUL : S_EMIT_INIT;
          end
        end
        S_LEN_MUL: state <= S_LEN_ACC;
        S_LEN_ACC: begin
          acc <= ((axis == 2'd0) ? 67'd0 : acc) + {1'b0, prod};
          if (axis == 2'd2) begin
            state <= S_LEN_SQ;
          end else begin
            axis <= axis + 2'd1;
            state <= S_LEN_MUL;
          end
        end
        S_LEN_SQ: begin
          if (acc[66:64] == 3'd0) begin
            rem <= {1'b0, acc[63:0]};
            sq_r <= '0;
            sq_b <= 64'h4000_0000_0000_0000;
            cnt <= 6'd32;
            root_tgt <= T_LEN;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sub_ge) begin
            rem <= sub_d;
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_ROOT_END;
          end
        end
        S_ROOT_END: begin
          if (root_tgt == T_SN) begin
            sn <= sq_r[30:0];
            state <= S_COR_INIT;
          end
        end
        S_W_START: begin
          if (k < 16'd2) begin
            state <= S_EMIT_INIT;
          end else if (la == 32'd0 || lb == 32'd0) begin
            ang <= '0;
            rec <= '0;
            cur <= '0;
            state <= S_EMIT_INIT;
          end else begin
            widx <= 2'd0;
            state <= S_W_MUL;
          end
        end
        S_W_MUL: state <= S_W_ACC;
        S_W_ACC: begin
          case (widx)
            2'd0: sum2 <= prod[63:0];
            2'd1: sum2 <= sum2 + prod[63:0];
            2'd2: ccr <= prod[63:0];
            default: den <= {prod[62:0], 1'b0};
          endcase
          widx <= widx + 2'd1;
          state <= (widx == 2'd3) ? S_W_CMP : S_W_MUL;
        end
        S_W_CMP: begin
          rem <= {1'b0, (sum2 >= ccr) ? (sum2 - ccr) : (ccr - sum2)};
          cos_neg <= (sum2 < ccr);
          state <= S_W_CHK;
        end
        S_W_CHK: begin
          // A ratio at or beyond one clamps the cosine's magnitude to one.
          if (rem[63:0] >= den) begin
            q <= 31'h4000_0000;
            state <= S_Q_SQ;
          end else begin
            feed <= '0;
            quo <= '0;
            cnt <= 6'd30;
            div_tgt <= D_COS;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= sub_ge ? sub_d : sub_l;
          feed <= {feed[34:0], 1'b0};
          quo <= {quo[34:0], sub_ge};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= S_DIV_END;
          end
        end
        S_DIV_END: begin
          case (div_tgt)
            D_COS: begin
              q <= {1'b0, quo[29:0]};
              state <= S_Q_SQ;
            end
            D_REC: begin
              rec <= (quo[33:32] != 2'd0) ? pcs_pkg::ALL_ONES : quo[31:0];
              state <= S_CUR_MUL;
            end
            default: begin
              cur <= (quo[35:32] != 4'd0) ? pcs_pkg::ALL_ONES : quo[31:0];
              state <= S_EMIT_INIT;
            end
          endcase
        end
        S_Q_SQ: state <= S_SN_INIT;
        S_SN_INIT: begin
          rem <= {1'b0, 64'h1000_0000_0000_0000 - prod[63:0]};
          sq_r <= '0;
          sq_b <= 64'h4000_0000_0000_0000;
          cnt <= 6'd32;
          root_tgt <= T_SN;
          state <= S_ROOT;
        end
        S_COR_INIT: begin
          // A negative x is first turned a quarter turn clockwise.
          if (x0 < 0) begin
            cor_x <= $signed({3'b0, sn});
            cor_y <= -x0;
            cor_z <= $signed(26'(pcs_pkg::DEG90_Q16));
          end else begin
            cor_x <= x0;
            cor_y <= $signed({3'b0, sn});
            cor_z <= '0;
          end
          cor_i <= '0;
          state <= S_COR;
        end
        S_COR: begin
          if (cor_y > 0) begin
            cor_x <= cor_x + cor_ys;
            cor_y <= cor_y - cor_xs;
            cor_z <= cor_z + cor_at;
          end else begin
            cor_x <= cor_x - cor_ys;
            cor_y <= cor_y + cor_xs;
            cor_z <= cor_z - cor_at;
          end
          cor_i <= cor_i + 5'd1;
          if (cor_i == 5'(pcs_pkg::CORDIC_STEPS - 1)) begin
            state <= S_COR_END;
          end
        end
        S_COR_END: begin
          if (cor_z < 0) begin
            ang <= '0;
          end else if (cor_z > $signed(26'(pcs_pkg::DEG180_Q16))) begin
            ang <= pcs_pkg::DEG180_Q16;
          end else begin
            ang <= 32'(unsigned'(cor_z));
          end
          state <= S_REC_INIT;
        end
        S_REC_INIT: begin
          if (lc != 32'd0) begin
            rem <= '0;
            den <= {32'b0, lc};
            feed <= {sn, 5'b0};
            quo <= '0;
            cnt <= 6'd34;
            div_tgt <= D_REC;
            state <= S_DIV;
          end else begin
            rec <= '0;
            state <= S_CUR_MUL;
          end
        end
        S_CUR_MUL: state <= S_CUR_INIT;
        S_CUR_INIT: begin
          rem <= '0;
          den <= {31'b0, {1'b0, la} + {1'b0, lb}};
          feed <= prod[51:16];
          quo <= '0;
          cnt <= 6'd36;
          div_tgt <= D_CUR;
          state <= S_DIV;
        end
        S_EMIT_INIT: begin
          if (k >= 16'd2) begin
            emit_step <= E_SEG;
          end else if (eos) begin
            emit_step <= (k >= 16'd1) ? E_LSEG : E_TOT;
          end else begin
            emit_step <= E_NONE;
          end
          ext_slot <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_step == E_NONE) begin
            state <= S_FINISH;
          end else if (out_free) begin
            out_valid <= 1'b1;
            o_strand <= strand_count;
            case (emit_step)
              E_SEG: begin
                o_kind <= pcs_pkg::KIND_SEGMENT;
                o_local <= k - 16'd2;
                o_global <= segment_count;
                o_a <= la;
                o_b <= seg_diff;
                o_c <= '0;
                o_last <= 1'b0;
                segment_count <= segment_count + 32'd1;
                length_sum <= sat_add(length_sum, la);
                if (la > mx[0]) mx[0] <= la;
                if (la < mn[0]) mn[0] <= la;
                if (k >= 16'd3) begin
                  if (diffv > mx[1]) mx[1] <= diffv;
                  if (diffv < mn[1]) mn[1] <= diffv;
                end
                emit_step <= E_PT;
              end
              E_PT: begin
                o_kind <= pcs_pkg::KIND_POINT;
                o_local <= k - 16'd1;
                o_global <= pt_total - 32'd1;
                o_a <= rec;
                o_b <= ang;
                o_c <= cur;
                o_last <= !eos;
                angle_sum <= sat_add(angle_sum, ang);
                previous_angle <= ang;
                if (rec > mx[2]) mx[2] <= rec;
                if (rec < mn[2]) mn[2] <= rec;
                if (ang > mx[3]) mx[3] <= ang;
                if (ang < mn[3]) mn[3] <= ang;
                if (cur > mx[4]) mx[4] <= cur;
                if (cur < mn[4]) mn[4] <= cur;
                emit_step <= eos ? E_LSEG : E_NONE;
              end
              E_LSEG: begin
                o_kind <= pcs_pkg::KIND_SEGMENT;
                o_local <= k - 16'd1;
                o_global <= segment_count;
                o_a <= lb;
                o_b <= '0;
                o_c <= '0;
                o_last <= 1'b0;
                segment_count <= segment_count + 32'd1;
                length_sum <= sat_add(length_sum, lb);
                if (lb > mx[0]) mx[0] <= lb;
                if (lb < mn[0]) mn[0] <= lb;
                emit_step <= E_TOT;
              end
              E_TOT: begin
                o_kind <= pcs_pkg::KIND_TOTALS;
                o_local <= '0;
                o_global <= strand_count;
                o_a <= {16'b0, k};
                o_b <= length_sum;
                o_c <= angle_sum;
                o_last <= 1'b0;
                emit_step <= E_EXT;
              end
              default: begin
                o_kind <= 3'(pcs_pkg::KIND_SEGLEN) + ext_slot;
                o_local <= '0;
                o_global <= strand_count;
                o_a <= mx[ext_slot];
                o_b <= mn[ext_slot];
                o_c <= '0;
                o_last <= (ext_slot == 3'd4);
                ext_slot <= ext_slot + 3'd1;
                if (ext_slot == 3'd4) begin
                  emit_step <= E_NONE;
                end
              end
            endcase
          end
        end
        S_FINISH: begin
          before_x <= last_x; before_y <= last_y; before_z <= last_z;
          last_x <= cx; last_y <= cy; last_z <= cz;
          pt_total <= pt_total + 32'd1;
          if (eos) begin
            strand_count <= strand_count + 32'd1;
            point_in_strand <= '0;
            length_sum <= '0;
            angle_sum <= '0;
            previous_angle <= '0;
            for (int i = 0; i < 5; i++) begin
              mx[i] <= '0;
              mn[i] <= pcs_pkg::ALL_ONES;
            end
          end else if (k < pcs_pkg::LOCAL_LIMIT) begin
            point_in_strand <= k + 16'd1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (len_store) begin
        case (len_sel)
          2'd0: lb <= len_value;
          2'd1: la <= len_value;
          default: lc <= len_value;
        endcase
        axis <= 2'd0;
        if (len_sel == 2'd0 && k >= 16'd2) begin
          len_sel <= 2'd1;
          state <= S_LEN_MUL;
        end else if (len_sel == 2'd1) begin
          len_sel <= 2'd2;
          state <= S_LEN_MUL;
        end else begin
          state <= S_W_START;
        end
      end
    end
  end

  assign points.ready = (state == S_IDLE);
  assign records.valid = out_valid;
  assign records.record_kind = o_kind;
  assign records.strand_number = o_strand;
  assign records.local_number = o_local;
  assign records.global_number = o_global;
  assign records.value_a = o_a;
  assign records.value_b = o_b;
  assign records.value_c = o_c;
  assign records.last_record = o_last;

  // An accepted item always makes the sequencer busy, so the point port is not ready in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    points.valid && points.ready |=> !points.ready)
    else $error("point port ready right after an accepted item");

  // Once a length has been tracked, its minimum cannot exceed its maximum.
  a_len_extrema: assert property (@(posedge clk) disable iff (rst)
    (mx[0] != 32'd0) |-> (mn[0] <= mx[0]))
    else $error("segment length minimum above maximum");

  // A new record only appears out of the emission step.
  a_record_source: assert property (@(posedge clk) disable iff (rst)
    $rose(records.valid) |-> $past(state) == S_EMIT)
    else $error("record raised outside emission");

endmodule
